[design/zsaf_pkg.sv]
// Shared types, constants and header byte functions for the stored-method ZIP framer.
package zsaf_pkg;

  localparam logic [2:0] KIND_OPEN   = 3'd0;
  localparam logic [2:0] KIND_BEGIN  = 3'd1;
  localparam logic [2:0] KIND_NAME   = 3'd2;
  localparam logic [2:0] KIND_DATA   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;
  localparam logic [2:0] KIND_FINISH = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ORDER    = 2'd2;

  localparam logic [31:0] SIG_LOCAL   = 32'h04034B50;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014B50;
  localparam logic [31:0] SIG_END     = 32'h06054B50;
  localparam logic [15:0] ZIP_VERSION = 16'd20;
  localparam int LOCAL_LEN   = 30;
  localparam int CENTRAL_LEN = 46;
  localparam int END_LEN     = 22;

  // Burst source selected by the datapath.
  localparam logic [2:0] SRC_NONE    = 3'd0;
  localparam logic [2:0] SRC_LOCAL   = 3'd1;
  localparam logic [2:0] SRC_ECHO    = 3'd2;
  localparam logic [2:0] SRC_DRAIN   = 3'd3;
  localparam logic [2:0] SRC_ENDREC  = 3'd4;

  typedef struct packed {
    logic       start;     // latch item and decide
    logic [2:0] src;       // source of current beat
    logic [5:0] idx;       // byte index in header
    logic       dir_wr;    // write one central byte
    logic       dir_rd;    // issue directory read
  } zsaf_cmd_t;

  // Central-directory record byte i.
  function automatic logic [7:0] central_byte(input logic [5:0] i, input logic [31:0] crc,
                                              input logic [31:0] size,
                                              input logic [15:0] len,
                                              input logic [31:0] at);
    logic [7:0] b;
    b = 8'h00;
    unique case (i)
      6'd0: b = SIG_CENTRAL[7:0];   6'd1: b = SIG_CENTRAL[15:8];
      6'd2: b = SIG_CENTRAL[23:16]; 6'd3: b = SIG_CENTRAL[31:24];
      6'd4, 6'd6: b = ZIP_VERSION[7:0];
      6'd16: b = crc[7:0];  6'd17: b = crc[15:8];  6'd18: b = crc[23:16];
      6'd19: b = crc[31:24];
      6'd20, 6'd24: b = size[7:0];   6'd21, 6'd25: b = size[15:8];
      6'd22, 6'd26: b = size[23:16]; 6'd23, 6'd27: b = size[31:24];
      6'd28: b = len[7:0]; 6'd29: b = len[15:8];
      6'd42: b = at[7:0];  6'd43: b = at[15:8]; 6'd44: b = at[23:16];
      6'd45: b = at[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] local_byte(input logic [5:0] i, input logic [31:0] crc,
                                            input logic [31:0] size,
                                            input logic [15:0] len);
    logic [7:0] b;
    b = 8'h00;
    unique case (i)
      6'd0: b = SIG_LOCAL[7:0];   6'd1: b = SIG_LOCAL[15:8];
      6'd2: b = SIG_LOCAL[23:16]; 6'd3: b = SIG_LOCAL[31:24];
      6'd4: b = ZIP_VERSION[7:0];
      6'd14: b = crc[7:0];  6'd15: b = crc[15:8];  6'd16: b = crc[23:16];
      6'd17: b = crc[31:24];
      6'd18, 6'd22: b = size[7:0];   6'd19, 6'd23: b = size[15:8];
      6'd20, 6'd24: b = size[23:16]; 6'd21, 6'd25: b = size[31:24];
      6'd26: b = len[7:0]; 6'd27: b = len[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_byte(input logic [5:0] i, input logic [15:0] cnt,
                                          input logic [31:0] dlen,
                                          input logic [31:0] dstart);
    logic [7:0] b;
    b = 8'h00;
    unique case (i)
      6'd0: b = SIG_END[7:0];   6'd1: b = SIG_END[15:8];
      6'd2: b = SIG_END[23:16]; 6'd3: b = SIG_END[31:24];
      6'd8, 6'd10: b = cnt[7:0]; 6'd9, 6'd11: b = cnt[15:8];
      6'd12: b = dlen[7:0];  6'd13: b = dlen[15:8];
      6'd14: b = dlen[23:16]; 6'd15: b = dlen[31:24];
      6'd16: b = dstart[7:0];  6'd17: b = dstart[15:8];
      6'd18: b = dstart[23:16]; 6'd19: b = dstart[31:24];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/zip_stored_archive_framer.sv]
// Top level: stored-method ZIP archive framer.
// Result beats start after the item passes S_CENT (a begin first writes its central
// record there; a drain also waits in S_PRE). The input stalls until the last beat is
// taken, and each drain beat waits for a registered memory read.
// Reset: synchronous active-low rst_n gives an open, empty archive; the
// directory memory is not cleared, only read where written.
module zip_stored_archive_framer #(
  parameter int DIRECTORY_BYTES = 4096,
  parameter int DRAIN_CHUNK     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_entry_size,
  input  logic [31:0] in_entry_crc,
  input  logic [12:0] in_name_length,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic        out_archive_done
);
  import zsaf_pkg::*;

  zsaf_cmd_t  cmd;
  logic [2:0] burst_src;
  logic [6:0] burst_len;

  // controller owns the handshakes and beat count
  zsaf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall,
    .burst_src, .burst_len, .cmd, .out_valid, .out_last
  );

  // datapath owns archive state and the directory store
  zsaf_dp #(.DIRECTORY_BYTES(DIRECTORY_BYTES), .DRAIN_CHUNK(DRAIN_CHUNK)) u_dp (
    .clk, .rst_n, .cmd, .beat(out_valid && !out_stall),
    .in_kind, .in_entry_size, .in_entry_crc, .in_name_length, .in_payload_byte,
    .burst_src, .burst_len, .out_byte(out_out_byte), .out_byte_valid,
    .out_status, .out_archive_done
  );
endmodule

[design/zsaf_ctrl.sv]
// Controller: sequences the bursts of one item and the handshakes.
module zsaf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  logic [2:0]           burst_src,   // decided by datapath on start
  input  logic [6:0]           burst_len,   // beats of this item (>=1)
  output zsaf_pkg::zsaf_cmd_t  cmd,
  output logic                 out_valid,
  output logic                 out_last
);
  import zsaf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CENT = 2'd1;   // decide burst; store central record for a begin
  localparam logic [1:0] S_PRE  = 2'd2;   // wait for registered directory read
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] len_r, len_nxt;
  logic [2:0] src_r, src_nxt;
  logic       ov_r, ov_nxt;
  logic       fire;

  assign fire     = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    src_nxt   = src_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.src   = src_r;
    cmd.idx   = cnt_r[5:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CENT;
        end
      end
      S_CENT: begin
        // first cycle after start: datapath has decided burst
        if (ov_r == 1'b0 && cnt_r == 7'd0 && len_r == 7'd0) begin
          len_nxt = burst_len;
          src_nxt = burst_src;
        end
        if (burst_src == SRC_LOCAL) begin
          cmd.dir_wr = 1'b1;
          cmd.idx    = cnt_r[5:0];
          if (cnt_r == 7'(CENTRAL_LEN - 1)) begin
            cnt_nxt   = '0;
            state_nxt = S_EMIT;
            ov_nxt    = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end else if (burst_src == SRC_DRAIN) begin
          cmd.dir_rd = 1'b1;
          state_nxt  = S_PRE;
        end else begin
          state_nxt = S_EMIT;
          ov_nxt    = 1'b1;
        end
      end
      S_PRE: begin
        state_nxt  = S_EMIT;
        ov_nxt     = 1'b1;
      end
      S_EMIT: begin
        if (fire) begin
          if (cnt_r == len_r - 7'd1) begin
            ov_nxt    = 1'b0;
            len_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
            if (src_r == SRC_DRAIN) begin
              cmd.dir_rd = 1'b1;
              ov_nxt     = 1'b0;
              state_nxt  = S_PRE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_last  = (cnt_r == len_r - 7'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
      src_r   <= SRC_NONE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      src_r   <= src_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

[design/zsaf_dp.sv]
// Datapath: archive state, directory memory and byte muxing.
module zsaf_dp #(
  parameter int DIRECTORY_BYTES = 4096,
  parameter int DRAIN_CHUNK     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  zsaf_pkg::zsaf_cmd_t cmd,
  input  logic                beat,        // output beat taken
  input  logic [2:0]          in_kind,
  input  logic [31:0]         in_entry_size,
  input  logic [31:0]         in_entry_crc,
  input  logic [12:0]         in_name_length,
  input  logic [7:0]          in_payload_byte,
  output logic [2:0]          burst_src,
  output logic [6:0]          burst_len,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic [1:0]          out_status,
  output logic                out_archive_done
);
  import zsaf_pkg::*;

  localparam int DW = $clog2(DIRECTORY_BYTES + 1);
  localparam int AW = $clog2(DIRECTORY_BYTES);

  logic [7:0]  dir_mem [DIRECTORY_BYTES];
  logic [7:0]  rd_data_r;

  logic [1:0]  err_r, err_nxt;
  logic [31:0] woff_r, woff_nxt;
  logic [DW-1:0] dlen_r, dlen_nxt;
  logic [15:0] ecnt_r, ecnt_nxt;
  logic [31:0] brem_r, brem_nxt;
  logic [12:0] nrem_r, nrem_nxt;
  logic [DW-1:0] doff_r, doff_nxt;
  logic [31:0] dstart_r, dstart_nxt;
  logic        fin_r, fin_nxt, open_r, open_nxt, drain_r, drain_nxt;
  logic [2:0]  src_r, src_nxt;
  logic [6:0]  blen_r, blen_nxt;
  logic [31:0] size_r, crc_r, at_r;
  logic [12:0] len_r;
  logic [7:0]  pb_r;
  logic [DW-1:0] cbase_r;
  logic [DW+13:0] need;
  logic [DW-1:0] left;
  logic [7:0]  wr_byte;
  logic [DW-1:0] wr_addr;
  logic        wr_en;

  assign need = (DW+14)'(dlen_r) + (DW+14)'(CENTRAL_LEN) + (DW+14)'(in_name_length);
  assign left = dlen_r - doff_r;

  always_comb begin
    err_nxt = err_r; woff_nxt = woff_r; dlen_nxt = dlen_r; ecnt_nxt = ecnt_r;
    brem_nxt = brem_r; nrem_nxt = nrem_r; doff_nxt = doff_r; dstart_nxt = dstart_r;
    fin_nxt = fin_r; open_nxt = open_r; drain_nxt = drain_r;
    src_nxt = src_r; blen_nxt = blen_r;
    wr_en = 1'b0; wr_addr = dlen_r; wr_byte = pb_r;
    if (cmd.start) begin
      src_nxt  = SRC_NONE;
      blen_nxt = 7'd1;
      if (in_kind == KIND_OPEN) begin
        err_nxt = ST_OK; woff_nxt = '0; dlen_nxt = '0; ecnt_nxt = '0;
        brem_nxt = '0; nrem_nxt = '0; doff_nxt = '0; dstart_nxt = '0;
        fin_nxt = 1'b0; open_nxt = 1'b0; drain_nxt = 1'b0;
      end else if (err_r != ST_OK) begin
      end else if (fin_r) begin
        err_nxt = ST_ORDER;
      end else begin
        unique case (in_kind)
          KIND_BEGIN: begin
            if (open_r || drain_r) err_nxt = ST_ORDER;
            else if (need > (DW+14)'(DIRECTORY_BYTES)) err_nxt = ST_FULL;
            else begin
              src_nxt = SRC_LOCAL; blen_nxt = 7'(LOCAL_LEN);
              nrem_nxt = in_name_length; brem_nxt = in_entry_size; open_nxt = 1'b1;
            end
          end
          KIND_NAME: begin
            if (!open_r || nrem_r == '0) err_nxt = ST_ORDER;
            else begin
              src_nxt = SRC_ECHO; nrem_nxt = nrem_r - 13'd1;
              wr_en = 1'b1; wr_byte = in_payload_byte; dlen_nxt = dlen_r + DW'(1);
            end
          end
          KIND_DATA: begin
            if (!open_r || nrem_r != '0 || brem_r == '0) err_nxt = ST_ORDER;
            else begin src_nxt = SRC_ECHO; brem_nxt = brem_r - 32'd1; end
          end
          KIND_END: begin
            if (!open_r || nrem_r != '0 || brem_r != '0) err_nxt = ST_ORDER;
            else begin open_nxt = 1'b0; ecnt_nxt = ecnt_r + 16'd1; end
          end
          KIND_FINISH: begin
            if (open_r) err_nxt = ST_ORDER;
            else begin
              if (!drain_r) begin
                drain_nxt = 1'b1; dstart_nxt = woff_r; doff_nxt = '0;
              end
              if (drain_r && doff_r < dlen_r) begin
                src_nxt = SRC_DRAIN;
                blen_nxt = (left > DW'(DRAIN_CHUNK)) ? 7'(DRAIN_CHUNK) : 7'(left);
              end else if (!drain_r && dlen_r != '0) begin
                src_nxt = SRC_DRAIN;
                blen_nxt = (dlen_r > DW'(DRAIN_CHUNK)) ? 7'(DRAIN_CHUNK) : 7'(dlen_r);
              end else begin
                src_nxt = SRC_ENDREC; blen_nxt = 7'(END_LEN); fin_nxt = 1'b1;
              end
            end
          end
          default: err_nxt = ST_ORDER;
        endcase
      end
    end
    if (cmd.dir_wr) begin
      wr_en   = 1'b1;
      wr_addr = cbase_r + DW'(cmd.idx);
      wr_byte = central_byte(cmd.idx, crc_r, size_r, {3'b000, len_r}, at_r);
      if (cmd.idx == 6'(CENTRAL_LEN - 1)) dlen_nxt = dlen_r + DW'(CENTRAL_LEN);
    end
    if (cmd.dir_rd) doff_nxt = doff_r + DW'(1);
    if (beat && src_r != SRC_NONE) woff_nxt = woff_r + 32'd1;
  end

  // Latch item fields and first central byte address on start; write and read directory.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size_r <= in_entry_size; crc_r <= in_entry_crc; len_r <= in_name_length;
      pb_r <= in_payload_byte; at_r <= woff_r; cbase_r <= dlen_r;
    end
    if (wr_en) dir_mem[wr_addr[AW-1:0]] <= wr_byte;
    if (cmd.dir_rd) rd_data_r <= dir_mem[doff_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= ST_OK; woff_r <= '0; dlen_r <= '0; ecnt_r <= '0; brem_r <= '0;
      nrem_r <= '0; doff_r <= '0; dstart_r <= '0; fin_r <= 1'b0; open_r <= 1'b0;
      drain_r <= 1'b0; src_r <= SRC_NONE; blen_r <= 7'd1;
    end else begin
      err_r <= err_nxt; woff_r <= woff_nxt; dlen_r <= dlen_nxt; ecnt_r <= ecnt_nxt;
      brem_r <= brem_nxt; nrem_r <= nrem_nxt; doff_r <= doff_nxt;
      dstart_r <= dstart_nxt; fin_r <= fin_nxt; open_r <= open_nxt;
      drain_r <= drain_nxt; src_r <= src_nxt; blen_r <= blen_nxt;
    end
  end

  assign burst_src = src_r;
  assign burst_len = blen_r;

  always_comb begin
    unique case (src_r)
      SRC_LOCAL:  out_byte = local_byte(cmd.idx, crc_r, size_r, {3'b000, len_r});
      SRC_ECHO:   out_byte = pb_r;
      SRC_DRAIN:  out_byte = rd_data_r;
      SRC_ENDREC: out_byte = end_byte(cmd.idx, ecnt_r, 32'(dlen_r), dstart_r);
      default:    out_byte = 8'h00;
    endcase
  end
  assign out_byte_valid   = (src_r != SRC_NONE);
  assign out_status       = err_r;
  assign out_archive_done = fin_r;
endmodule

[design/zsaf_checker.sv]
// Port-level checker for the framer, bound to the top level.
module zsaf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_byte_valid,
  input logic [1:0] out_status,
  input logic [7:0] out_out_byte
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte))
    else $error("stalled beat changed");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during burst");
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'd0 |-> !out_byte_valid)
    else $error("byte after error");
endmodule

bind zip_stored_archive_framer zsaf_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_byte_valid, .out_status, .out_out_byte
);
